### design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, register indexes and constants of the packet timestamp tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int TS_W       = 64;
    localparam int STEP_W     = 30;
    localparam int FRAC_W     = 32;
    localparam int ACC_W      = FRAC_W + 1;
    localparam int WINDOW_W   = 40;
    localparam int LEAD_W     = 30;
    localparam int LIMIT_W    = 4;
    localparam int SEC_W      = 32;
    localparam int NSEC_W     = 30;
    localparam int PROD_W     = SEC_W + NSEC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [NSEC_W-1:0] NS_PER_SEC      = NSEC_W'(1000000000);
    localparam logic [ACC_W-1:0]  ONE_NS_FRACTION = ACC_W'(64'h1_0000_0000);

    localparam logic [STEP_W-1:0]   STEP_NS_RST    = STEP_W'(666666);
    localparam logic [FRAC_W-1:0]   STEP_FRAC_RST  = FRAC_W'(64'd2863311530);
    localparam logic [WINDOW_W-1:0] HALF_WIN_RST   = WINDOW_W'(10000000);
    localparam logic [LEAD_W-1:0]   LEAD_RST       = '0;
    localparam logic [LIMIT_W-1:0]  BAD_LIMIT_RST  = LIMIT_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_NS        = 3'd0,
        REG_STEP_FRACTION  = 3'd1,
        REG_HALF_WINDOW_NS = 3'd2,
        REG_LEAD_OFFSET_NS = 3'd3,
        REG_BAD_LIMIT      = 3'd4
    } ptt_reg_t;

    typedef enum logic {
        ACT_ADVANCE   = 1'b0,
        ACT_REFERENCE = 1'b1
    } ptt_action_t;

    typedef struct packed {
        ptt_action_t       action;
        logic [TS_W-1:0]   ref_time;
    } ptt_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step_ns;
        logic [FRAC_W-1:0]   step_fraction;
        logic [WINDOW_W-1:0] half_window_ns;
        logic [LIMIT_W-1:0]  bad_limit;
    } ptt_cfg_t;

endpackage

### design/ptt_state.sv
// ----------------------------------------------------------------------------
// ptt_state
// Timestamp state update and result register: advances the timestamp with its
// fractional carry, or checks a reference time against the window and resyncs.
// ----------------------------------------------------------------------------
module ptt_state import ptt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptt_cfg_t            cfg,
    input  logic                item_valid,
    input  ptt_item_t           item,
    output logic                item_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TS_W-1:0]     m_timestamp,
    output logic                m_out_of_window,
    output logic                m_resynced
);

    logic [TS_W-1:0]    packet_time_reg, packet_time_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [LIMIT_W-1:0] bad_count_reg, bad_count_next;
    logic               m_valid_reg;
    logic [TS_W-1:0]    m_timestamp_reg;
    logic               m_out_of_window_reg, m_resynced_reg;

    logic               load;
    logic [ACC_W-1:0]   acc_sum;
    logic               carry;
    logic [TS_W-1:0]    diff;
    logic [TS_W:0]      diff_ext, hw_ext, hw_neg;
    logic               outside;
    logic [LIMIT_W-1:0] count_inc;
    logic               bad_flag, resync_flag;

    assign item_ready = !m_valid_reg || m_ready;
    assign load       = item_valid && item_ready;

    // fractional carry
    assign acc_sum = acc_reg + {1'b0, cfg.step_fraction};
    assign carry   = acc_sum > ONE_NS_FRACTION;

    // window check
    assign diff     = item.ref_time - packet_time_reg;
    assign diff_ext = {diff[TS_W-1], diff};
    assign hw_ext   = {(TS_W + 1 - WINDOW_W)'(0), cfg.half_window_ns};
    assign hw_neg   = (TS_W + 1)'(0) - hw_ext;
    assign outside  = ($signed(diff_ext) > $signed(hw_ext))
                   || ($signed(diff_ext) < $signed(hw_neg));
    assign count_inc = bad_count_reg + LIMIT_W'(1);

    always_comb begin
        packet_time_next = packet_time_reg;
        acc_next         = acc_reg;
        bad_count_next   = bad_count_reg;
        bad_flag         = 1'b0;
        resync_flag      = 1'b0;
        unique case (item.action)
            ACT_ADVANCE: begin
                packet_time_next = packet_time_reg
                                 + {(TS_W - STEP_W)'(0), cfg.step_ns}
                                 + {(TS_W - 1)'(0), carry};
                acc_next = carry ? (acc_sum - ONE_NS_FRACTION) : acc_sum;
            end
            ACT_REFERENCE: begin
                if (outside) begin
                    bad_flag = 1'b1;
                    if (count_inc >= cfg.bad_limit) begin
                        packet_time_next = item.ref_time;
                        bad_count_next   = '0;
                        resync_flag      = 1'b1;
                    end else begin
                        bad_count_next = count_inc;
                    end
                end else begin
                    bad_count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_time_reg     <= '0;
            acc_reg             <= '0;
            bad_count_reg       <= '0;
            m_valid_reg         <= 1'b0;
            m_timestamp_reg     <= '0;
            m_out_of_window_reg <= 1'b0;
            m_resynced_reg      <= 1'b0;
        end else begin
            if (load) begin
                packet_time_reg     <= packet_time_next;
                acc_reg             <= acc_next;
                bad_count_reg       <= bad_count_next;
                m_timestamp_reg     <= packet_time_next;
                m_out_of_window_reg <= bad_flag;
                m_resynced_reg      <= resync_flag;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_timestamp     = m_timestamp_reg;
    assign m_out_of_window = m_out_of_window_reg;
    assign m_resynced      = m_resynced_reg;

    // a resync only follows an out-of-window sample
    a_resync_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_resynced_reg |-> m_out_of_window_reg)
        else $error("resync without out-of-window sample");

    // the shown timestamp is the tracked state
    a_ts_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_timestamp_reg == packet_time_reg)
        else $error("result timestamp differs from state");

    // a resync clears the bad count
    a_resync_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        load && resync_flag |=> bad_count_reg == '0)
        else $error("bad count not cleared on resync");

    // the remainder never passes one nanosecond
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ONE_NS_FRACTION)
        else $error("fraction accumulator out of range");

endmodule

### design/packet_timestamp_tracker.sv
// ----------------------------------------------------------------------------
// packet_timestamp_tracker
// Nanosecond audio packet timestamp with fractional step and reference resync.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result transaction, in order.
// The block takes one transaction per cycle while m_ready holds; a result
// passes through the product register, the reference-time register and the
// result register. The throughput is set by the timestamp update, a loop
// through the state registers. Configuration writes take effect at once and
// are meant to happen while no transaction is in flight.
module packet_timestamp_tracker import ptt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [SEC_W-1:0]      s_ref_seconds,
    input  logic [NSEC_W-1:0]     s_ref_nanoseconds,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TS_W-1:0]       m_timestamp,
    output logic                  m_out_of_window,
    output logic                  m_resynced
);

    ptt_cfg_t            cfg_reg;
    logic [LEAD_W-1:0]   lead_reg;

    logic                a_valid_reg;
    ptt_action_t         a_action_reg;
    logic [PROD_W-1:0]   a_product_reg;
    logic [NSEC_W-1:0]   a_nsec_reg;
    logic                a_ready;

    logic                b_valid_reg;
    ptt_item_t           b_item_reg;
    logic                b_ready;

    logic [PROD_W-1:0]   product;
    logic [TS_W-1:0]     ref_time;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_ns        <= STEP_NS_RST;
            cfg_reg.step_fraction  <= STEP_FRAC_RST;
            cfg_reg.half_window_ns <= HALF_WIN_RST;
            cfg_reg.bad_limit      <= BAD_LIMIT_RST;
            lead_reg               <= LEAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_NS:        cfg_reg.step_ns        <= cfg_data[STEP_W-1:0];
                REG_STEP_FRACTION:  cfg_reg.step_fraction  <= cfg_data[FRAC_W-1:0];
                REG_HALF_WINDOW_NS: cfg_reg.half_window_ns <= cfg_data[WINDOW_W-1:0];
                REG_LEAD_OFFSET_NS: lead_reg               <= cfg_data[LEAD_W-1:0];
                REG_BAD_LIMIT:      cfg_reg.bad_limit      <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // seconds to nanoseconds
    assign product = PROD_W'(s_ref_seconds) * PROD_W'(NS_PER_SEC);
    assign s_ready = a_ready;
    assign a_ready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && a_ready) begin
            a_action_reg  <= ptt_action_t'(s_action);
            a_product_reg <= product;
            a_nsec_reg    <= s_ref_nanoseconds;
        end
    end

    // reference time with lead
    assign ref_time = {(TS_W - PROD_W)'(0), a_product_reg}
                    + {(TS_W - NSEC_W)'(0), a_nsec_reg}
                    + {(TS_W - LEAD_W)'(0), lead_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_item_reg.action   <= a_action_reg;
            b_item_reg.ref_time <= ref_time;
        end
    end

    ptt_state u_state (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .item_valid      (b_valid_reg),
        .item            (b_item_reg),
        .item_ready      (b_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_timestamp     (m_timestamp),
        .m_out_of_window (m_out_of_window),
        .m_resynced      (m_resynced)
    );

endmodule

### tb/sv/packet_timestamp_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_timestamp_tracker_test
// Self-checking bench for the packet timestamp tracker. A transaction-level
// model of the timestamp, the fraction remainder and the bad-sample count
// predicts every result; directed cases hit the register extremes and the
// exact-one remainder, random traffic runs under several idle and stall
// mixes, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module packet_timestamp_tracker_test;
    import ptt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] NS_SEC = 64'd1000000000;
    localparam logic [ACC_W-1:0] ONE_NS = 33'h1_0000_0000;

    typedef struct packed {
        logic [TS_W-1:0] timestamp;
        logic            out_of_window;
        logic            resynced;
    } stamp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_action = 1'b0;
    logic [SEC_W-1:0]      s_ref_seconds = '0;
    logic [NSEC_W-1:0]     s_ref_nanoseconds = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TS_W-1:0]       m_timestamp;
    logic                  m_out_of_window;
    logic                  m_resynced;

    // tracker model state and register copies
    logic [TS_W-1:0]     track_time = '0;
    logic [ACC_W-1:0]    frac_acc = '0;
    logic [LIMIT_W-1:0]  miss_count = '0;
    logic [STEP_W-1:0]   cfg_step = STEP_NS_RST;
    logic [FRAC_W-1:0]   cfg_frac = STEP_FRAC_RST;
    logic [WINDOW_W-1:0] cfg_half_win = HALF_WIN_RST;
    logic [LEAD_W-1:0]   cfg_lead = LEAD_RST;
    logic [LIMIT_W-1:0]  cfg_limit = BAD_LIMIT_RST;

    stamp_t stamp_queue[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int error_count = 0;
    int cycle_count = 0;
    int n_advance = 0;
    int n_reference = 0;
    int n_bad = 0;
    int n_resync = 0;
    int n_checked = 0;

    packet_timestamp_tracker DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_ref_seconds     (s_ref_seconds),
        .s_ref_nanoseconds (s_ref_nanoseconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_timestamp       (m_timestamp),
        .m_out_of_window   (m_out_of_window),
        .m_resynced        (m_resynced)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check each transaction, drive ready
    always @(posedge aclk) begin
        stamp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stamp_queue.size() == 0) begin
                $error("result transaction with no expected timestamp");
                error_count++;
            end else begin
                want = stamp_queue.pop_front();
                n_checked++;
                if (m_timestamp !== want.timestamp) begin
                    $error("timestamp: expected %0d, actual %0d",
                           $signed(want.timestamp), $signed(m_timestamp));
                    error_count++;
                end
                if (m_out_of_window !== want.out_of_window) begin
                    $error("out_of_window: expected %0b, actual %0b",
                           want.out_of_window, m_out_of_window);
                    error_count++;
                end
                if (m_resynced !== want.resynced) begin
                    $error("resynced: expected %0b, actual %0b",
                           want.resynced, m_resynced);
                    error_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void compute_stamp(input ptt_action_t act,
                                          input logic [SEC_W-1:0] secs,
                                          input logic [NSEC_W-1:0] nsec);
        logic [63:0] ref_time;
        logic [63:0] diff;
        logic [63:0] mag;
        stamp_t      res;
        res = '0;
        if (act == ACT_ADVANCE) begin
            n_advance++;
            track_time = track_time + 64'(cfg_step);
            frac_acc = frac_acc + {1'b0, cfg_frac};
            if (frac_acc > ONE_NS) begin
                track_time = track_time + 64'd1;
                frac_acc = frac_acc - ONE_NS;
            end
        end else begin
            n_reference++;
            ref_time = 64'(secs) * NS_SEC + 64'(nsec) + 64'(cfg_lead);
            diff = ref_time - track_time;
            mag = diff[63] ? (64'd0 - diff) : diff;
            if (mag > 64'(cfg_half_win)) begin
                n_bad++;
                res.out_of_window = 1'b1;
                miss_count = miss_count + 4'd1;
                if (miss_count >= cfg_limit) begin
                    n_resync++;
                    track_time = ref_time;
                    miss_count = '0;
                    res.resynced = 1'b1;
                end
            end else begin
                miss_count = '0;
            end
        end
        res.timestamp = track_time;
        stamp_queue.push_back(res);
    endfunction

    task automatic send_item(input ptt_action_t act, input logic [SEC_W-1:0] secs,
                             input logic [NSEC_W-1:0] nsec);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= act;
        s_ref_seconds     <= secs;
        s_ref_nanoseconds <= nsec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_stamp(act, secs, nsec);
    endtask

    task automatic send_advance();
        send_item(ACT_ADVANCE, $urandom, NSEC_W'($urandom));
    endtask

    // reference aimed at the current timestamp plus an offset
    task automatic send_reference_at(input longint off);
        logic [63:0] target;
        logic [63:0] base;
        logic [63:0] secs;
        target = track_time + 64'(off);
        base = (target >= 64'(cfg_lead)) ? target - 64'(cfg_lead) : target;
        secs = base / NS_SEC;
        if (secs > 64'hFFFF_FFFF)
            send_item(ACT_REFERENCE, $urandom, NSEC_W'(base % NS_SEC));
        else
            send_item(ACT_REFERENCE, SEC_W'(secs), NSEC_W'(base % NS_SEC));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (stamp_queue.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input ptt_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_STEP_NS:        cfg_step = data[STEP_W-1:0];
            REG_STEP_FRACTION:  cfg_frac = data[FRAC_W-1:0];
            REG_HALF_WINDOW_NS: cfg_half_win = data[WINDOW_W-1:0];
            REG_LEAD_OFFSET_NS: cfg_lead = data[LEAD_W-1:0];
            REG_BAD_LIMIT:      cfg_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_item();
        int     pick;
        longint span;
        pick = $urandom_range(99);
        span = (cfg_half_win > 40'd100000000) ? 64'd200000000
                                               : 2 * longint'(cfg_half_win) + 4;
        if (pick < 50)
            send_advance();
        else if (pick < 85)
            send_reference_at(longint'($urandom_range(32'(2 * span))) - span);
        else
            send_item(ACT_REFERENCE, $urandom, NSEC_W'($urandom));
    endtask

    task automatic load_random_config();
        wait_idle();
        write_reg(REG_STEP_NS, ($urandom_range(9) == 0) ? 40'h3FFF_FFFF
                                                        : 40'($urandom_range(2000000)));
        write_reg(REG_STEP_FRACTION, 40'($urandom));
        write_reg(REG_HALF_WINDOW_NS, ($urandom_range(4) == 0) ? 40'd0
                                      : 40'($urandom_range(1, 5000000)));
        write_reg(REG_LEAD_OFFSET_NS, 40'($urandom_range(0, 32'h3FFF_FFFF)));
        write_reg(REG_BAD_LIMIT, ($urandom_range(4) == 0) ? 40'($urandom_range(6, 15))
                                                          : 40'($urandom_range(1, 5)));
    endtask

    task automatic test_defaults();
        repeat (4) send_advance();
        send_reference_at(0);
        repeat (3) send_reference_at(longint'(64'd50000000));
    endtask

    task automatic test_fraction_edges();
        wait_idle();
        write_reg(REG_STEP_NS, 40'd0);
        write_reg(REG_STEP_FRACTION, 40'h0_8000_0000);
        repeat (4) send_advance();
        wait_idle();
        write_reg(REG_STEP_FRACTION, 40'h0_FFFF_FFFF);
        repeat (2) send_advance();
        wait_idle();
        write_reg(REG_STEP_NS, 40'h3FFF_FFFF);
        write_reg(REG_STEP_FRACTION, 40'd0);
        send_advance();
    endtask

    task automatic test_reference_extremes();
        wait_idle();
        write_reg(REG_HALF_WINDOW_NS, 40'd0);
        write_reg(REG_BAD_LIMIT, 40'd0);
        write_reg(REG_LEAD_OFFSET_NS, 40'h3FFF_FFFF);
        send_item(ACT_REFERENCE, '0, '0);
        send_item(ACT_REFERENCE, '1, '1);
        send_item(ACT_REFERENCE, '1, '0);
        send_reference_at(0);
        wait_idle();
        write_reg(REG_HALF_WINDOW_NS, 40'hFF_FFFF_FFFF);
        write_reg(REG_BAD_LIMIT, 40'd15);
        write_reg(REG_LEAD_OFFSET_NS, 40'd0);
        send_item(ACT_REFERENCE, '0, '0);
        send_item(ACT_REFERENCE, '0, 30'd999999999);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
        load_random_config();
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (count) send_random_item();
        wait_idle();
    endtask

    task automatic test_backpressure();
        load_random_config();
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge aclk);
        hold_request = 300;
        repeat (60) send_random_item();
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_fraction_edges();
        test_reference_extremes();
        test_random_traffic(0, 0, 365);
        test_random_traffic(47, 0, 365);
        test_random_traffic(0, 47, 365);
        test_random_traffic(33, 33, 365);
        test_backpressure();
        wait_idle();
        repeat (10) @(posedge aclk);
        $display("checked %0d results: %0d advances, %0d references", n_checked,
                 n_advance, n_reference);
        $display("%0d out-of-window samples, %0d resyncs, idle/stall mixes and a full stall",
                 n_bad, n_resync);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
